>>> src/dhpd_pkg.sv
// Package with the command and status codes of the handler dispatcher.
`timescale 1ns / 1ps
`default_nettype none
package dhpd_pkg;
   localparam logic CMD_ACTIVATE = 1'b0;
   localparam logic CMD_DISPATCH = 1'b1;
   localparam logic [1:0] ST_ACTIVATED = 2'd0;
   localparam logic [1:0] ST_DISPATCHED = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_BAD_PRIO = 2'd3;
   localparam int PRIO_BITS = 6;
   localparam int HID_BITS = 6;
   localparam int STATUS_BITS = 2;
   localparam int RUN_PRIO_BITS = 5;
   localparam int RSP_COUNT_BITS = 16;
   localparam int MAX_LEVELS = 32;
endpackage
`default_nettype wire

>>> src/dhpd_hmem.sv
// Handler memory: pending count, queued flag and next link of each handler.
`timescale 1ns / 1ps
`default_nettype none
module dhpd_hmem #(
   parameter int HANDLERS = 64,
   parameter int COUNT_BITS = 16
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [$clog2(HANDLERS)-1:0]  wr_addr,
   input  wire  [COUNT_BITS+$clog2(HANDLERS):0] wr_data,
   input  wire  [$clog2(HANDLERS)-1:0]  rd_addr,
   output logic [COUNT_BITS+$clog2(HANDLERS):0] rd_data
);
   localparam int W = COUNT_BITS + $clog2(HANDLERS) + 1;
   logic [W-1:0] mem [HANDLERS];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> src/deferred_handler_priority_dispatcher_top.sv
// Top level of the deferred handler priority dispatcher.
// A result is registered in the LINK state and shows on rsp_valid after READ and LINK.
// A new item is not taken until the last is done; busy stays high while an item is
// read, modified and written back through the handler memory.
// Reset clears the level bitmap and sweeps the handler memory, one entry a
// cycle, during which busy stays high.
`timescale 1ns / 1ps
`default_nettype none
module deferred_handler_priority_dispatcher_top #(
   parameter int LEVELS = 32,
   parameter int HANDLERS = 64,
   parameter int COUNT_BITS = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire                               req_cmd,
   input  wire  [dhpd_pkg::HID_BITS-1:0]     req_handler_id,
   input  wire  [dhpd_pkg::PRIO_BITS-1:0]    req_priority_req,
   output logic                              rsp_valid,
   output logic [dhpd_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic [dhpd_pkg::HID_BITS-1:0]     rsp_run_handler,
   output logic [dhpd_pkg::RUN_PRIO_BITS-1:0] rsp_run_priority,
   output logic [dhpd_pkg::RSP_COUNT_BITS-1:0] rsp_remaining_count
);
   import dhpd_pkg::*;
   localparam int HB = $clog2(HANDLERS);
   localparam int LB = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int W = COUNT_BITS + HB + 1;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_READ = 3'd2,
                          S_LINK = 3'd3, S_EXEC = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [HB:0] clr_ff, clr_in;
   logic [LEVELS-1:0] pend_ff, pend_in;
   logic [HB-1:0] head_ff [LEVELS];
   logic [HB-1:0] tail_ff [LEVELS];
   logic cmd_ff;
   logic [HB-1:0] h_ff;
   logic [PRIO_BITS-1:0] prio_ff;
   logic [LB-1:0] lvl_ff;
   logic found_ff;
   logic [HB-1:0] sel_ff;
   logic q_ff;
   logic we;
   logic [HB-1:0] wa, ra;
   logic [W-1:0] wd, rd;
   logic [LB-1:0] lvl_enc;
   logic found_enc;
   logic [COUNT_BITS-1:0] cnt, cnt_new;
   logic q;
   logic [HB-1:0] nxt;

   dhpd_hmem #(.HANDLERS(HANDLERS), .COUNT_BITS(COUNT_BITS)) u_hmem (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd)
   );

   // Lowest set level bit.
   always_comb begin
      lvl_enc = '0;
      found_enc = 1'b0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            lvl_enc = LB'(i);
            found_enc = 1'b1;
         end
      end
   end

   assign cnt = rd[COUNT_BITS-1:0];
   assign q = rd[COUNT_BITS];
   assign nxt = rd[W-1:COUNT_BITS+1];
   assign busy = (state_ff != S_IDLE);

   // Sequencer, memory access and result.
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      pend_in = pend_ff;
      we = 1'b0;
      wa = '0;
      wd = '0;
      ra = (cmd_ff == CMD_DISPATCH) ? sel_ff : h_ff;
      cnt_new = cnt;
      case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            wa = clr_ff[HB-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (HB+1)'(HANDLERS - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (start) state_in = S_READ;
         S_READ: state_in = S_LINK;
         S_LINK: begin
            // Appending to a non-empty level rewrites the tail's link, read here.
            ra = tail_ff[prio_ff[LB-1:0]];
            state_in = S_EXEC;
            if (cmd_ff == CMD_ACTIVATE && prio_ff < PRIO_BITS'(LEVELS)) begin
               we = 1'b1;
               wa = h_ff;
               cnt_new = (cnt < CNT_MAX) ? cnt + 1'b1 : cnt;
               wd = {nxt, 1'b1, cnt_new};
            end else if (cmd_ff == CMD_DISPATCH && found_ff) begin
               we = 1'b1;
               wa = sel_ff;
               cnt_new = (cnt > 0) ? cnt - 1'b1 : cnt;
               wd = {nxt, (cnt_new != 0), cnt_new};
               if (cnt_new == 0 && tail_ff[lvl_ff] == sel_ff) pend_in[lvl_ff] = 1'b0;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            if (cmd_ff == CMD_ACTIVATE && prio_ff < PRIO_BITS'(LEVELS) && !q_ff
                && pend_ff[prio_ff[LB-1:0]] && tail_ff[prio_ff[LB-1:0]] != h_ff) begin
               we = 1'b1;
               wa = tail_ff[prio_ff[LB-1:0]];
               wd = {h_ff, rd[COUNT_BITS:0]};
            end
            if (cmd_ff == CMD_ACTIVATE && prio_ff < PRIO_BITS'(LEVELS) && !q_ff)
               pend_in[prio_ff[LB-1:0]] = 1'b1;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         pend_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         pend_ff <= pend_in;
         rsp_valid <= 1'b0;
         if (state_ff == S_IDLE && start) begin
            cmd_ff <= req_cmd;
            h_ff <= HB'(req_handler_id % HANDLERS);
            prio_ff <= req_priority_req;
            lvl_ff <= lvl_enc;
            found_ff <= found_enc;
            sel_ff <= head_ff[lvl_enc];
         end
         if (state_ff == S_LINK) begin
            q_ff <= q;
            rsp_valid <= 1'b1;
            rsp_run_handler <= '0;
            rsp_run_priority <= '0;
            rsp_remaining_count <= RSP_COUNT_BITS'(cnt_new);
            if (cmd_ff == CMD_ACTIVATE) begin
               if (prio_ff < PRIO_BITS'(LEVELS)) begin
                  rsp_status <= ST_ACTIVATED;
               end else begin
                  rsp_status <= ST_BAD_PRIO;
               end
            end else if (!found_ff) begin
               rsp_status <= ST_EMPTY;
               rsp_remaining_count <= '0;
            end else begin
               rsp_status <= ST_DISPATCHED;
               rsp_run_handler <= HID_BITS'(sel_ff);
               rsp_run_priority <= RUN_PRIO_BITS'(lvl_ff);
               if (cnt_new == 0 && tail_ff[lvl_ff] != sel_ff) head_ff[lvl_ff] <= nxt;
            end
         end
         if (state_ff == S_EXEC && cmd_ff == CMD_ACTIVATE && prio_ff < PRIO_BITS'(LEVELS)
             && !q_ff) begin
            tail_ff[prio_ff[LB-1:0]] <= h_ff;
            if (!pend_ff[prio_ff[LB-1:0]]) head_ff[prio_ff[LB-1:0]] <= h_ff;
         end
      end
   end
endmodule
`default_nettype wire
